>>> hw/rtl/hsvrgb_pkg.sv
// hsv_to_rgb shared package: constants, stage payload types, enable struct
// and the sector base table. No dependencies.
`timescale 1ns / 1ps

package hsvrgb_pkg;

  localparam int unsigned HueW    = 15;
  localparam int unsigned ChanW   = 8;
  localparam int unsigned FracW   = 12;
  localparam int unsigned ProdW   = 20;   // frac * s, holds up to DenQt
  localparam int unsigned ScaleW  = 28;   // v * (DenQt - x)

  localparam logic [FracW-1:0]  HueSector = 12'd3840;
  localparam logic [ProdW-1:0]  DenQt     = 20'd979200;   // 3840 * 255
  localparam logic [ChanW-1:0]  Full8     = 8'd255;
  localparam logic [6:0]        HalfFull8 = 7'd127;
  localparam logic [ScaleW-1:0] HalfDenQt = 28'd489600;

  // floor(x / 255) = (x * Inv255) >> 23 for x below 2^16
  localparam logic [15:0]       Inv255    = 16'd32897;
  localparam int unsigned       Sh255     = 23;
  // floor(y / 3825) = (y * Inv3825) >> 30 for y below 2^20
  localparam logic [18:0]       Inv3825   = 19'd280717;
  localparam int unsigned       Sh3825    = 30;
  localparam int unsigned       YqW       = ScaleW - 8;
  localparam int unsigned       QpW       = YqW + 19;

  localparam int unsigned DataInW  = 32;
  localparam int unsigned DataOutW = 24;

  typedef logic [2:0] sector_t;

  localparam sector_t SecRed     = 3'd0;
  localparam sector_t SecYellow  = 3'd1;
  localparam sector_t SecGreen   = 3'd2;
  localparam sector_t SecCyan    = 3'd3;
  localparam sector_t SecBlue    = 3'd4;

  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
    logic s4;
    logic s5;
  } stage_en_t;

  typedef struct packed {
    sector_t          sector;
    logic [FracW-1:0] frac;
    logic [ChanW-1:0] sat;
    logic [ChanW-1:0] bright;
  } split_t;

  typedef struct packed {
    sector_t           sector;
    logic [ChanW-1:0]  bright;
    logic [ProdW-1:0]  frac_sat;   // frac * s
    logic [ProdW-1:0]  rest_sat;   // (3840 - frac) * s
    logic [15:0]       pv;         // v * (255 - s)
  } prod_t;

  typedef struct packed {
    sector_t           sector;
    logic [ChanW-1:0]  bright;
    logic [ScaleW-1:0] mq;
    logic [ScaleW-1:0] mt;
    logic [31:0]       pm;
  } scale_t;

  // raw hue sector index times one sector width
  function automatic logic [HueW-1:0] sector_base(input logic [3:0] k);
    logic [HueW-1:0] b;
    b = HueW'(k) * HueW'(HueSector);
    return b;
  endfunction

endpackage

>>> hw/rtl/hsvrgb_split.sv
// hsv_to_rgb stage 1: folds the hue into six sectors and splits off the
// fraction inside the sector. Depends on hsvrgb_pkg.
`timescale 1ns / 1ps

module hsvrgb_split import hsvrgb_pkg::*; (
  input  logic             clk_i,
  input  stage_en_t        en_i,
  input  logic [HueW-1:0]  hue_i,
  input  logic [ChanW-1:0] sat_i,
  input  logic [ChanW-1:0] bright_i,
  output split_t           split_o
);

  logic [3:0]      raw_k;
  logic [HueW-1:0] base;
  split_t          split_d, split_q;

  // count of sector boundaries at or below hue, up to 8 for a 15-bit hue
  always_comb begin
    raw_k = '0;
    for (int k = 1; k <= 8; k++) begin
      if (hue_i >= sector_base(4'(k))) begin
        raw_k = 4'(k);
      end
    end
  end

  always_comb begin
    base           = sector_base(raw_k);
    split_d.frac   = FracW'(hue_i - base);
    // one full turn is six sectors
    split_d.sector = (raw_k >= 4'd6) ? sector_t'(raw_k - 4'd6) : sector_t'(raw_k);
    split_d.sat    = sat_i;
    split_d.bright = bright_i;
  end

  always_ff @(posedge clk_i) begin
    if (en_i.s1) begin
      split_q <= split_d;
    end
  end

  assign split_o = split_q;

endmodule

>>> hw/rtl/hsvrgb_prod.sv
// hsv_to_rgb stages 2 and 3: saturation products, then scaling by value.
// Depends on hsvrgb_pkg.
`timescale 1ns / 1ps

module hsvrgb_prod import hsvrgb_pkg::*; (
  input  logic      clk_i,
  input  stage_en_t en_i,
  input  split_t    split_i,
  output scale_t    scale_o
);

  prod_t            prod_d, prod_q;
  scale_t           scale_d, scale_q;
  logic [FracW-1:0] rest;
  logic [15:0]      px;

  always_comb begin
    rest             = HueSector - split_i.frac;
    prod_d.sector    = split_i.sector;
    prod_d.bright    = split_i.bright;
    prod_d.frac_sat  = ProdW'(split_i.frac) * ProdW'(split_i.sat);
    prod_d.rest_sat  = ProdW'(rest) * ProdW'(split_i.sat);
    prod_d.pv        = 16'(split_i.bright) * 16'(Full8 - split_i.sat);
  end

  always_ff @(posedge clk_i) begin
    if (en_i.s2) begin
      prod_q <= prod_d;
    end
  end

  always_comb begin
    // half of 255 rounds p; the multiply by Inv255 is here, the shift in the next stage
    px             = prod_q.pv + 16'(HalfFull8);
    scale_d.sector = prod_q.sector;
    scale_d.bright = prod_q.bright;
    scale_d.mq     = ScaleW'(prod_q.bright) * ScaleW'(DenQt - prod_q.frac_sat);
    scale_d.mt     = ScaleW'(prod_q.bright) * ScaleW'(DenQt - prod_q.rest_sat);
    scale_d.pm     = 32'(px) * 32'(Inv255);
  end

  always_ff @(posedge clk_i) begin
    if (en_i.s3) begin
      scale_q <= scale_d;
    end
  end

  assign scale_o = scale_q;

endmodule

>>> hw/rtl/hsvrgb_norm.sv
// hsv_to_rgb stages 4 and 5: rounded divide of q and t by 979200 through a
// reciprocal multiply, then the sector permutation. Depends on hsvrgb_pkg.
`timescale 1ns / 1ps

module hsvrgb_norm import hsvrgb_pkg::*; (
  input  logic              clk_i,
  input  stage_en_t         en_i,
  input  scale_t            scale_i,
  output logic [ChanW-1:0]  red_o,
  output logic [ChanW-1:0]  green_o,
  output logic [ChanW-1:0]  blue_o
);

  typedef struct packed {
    sector_t          sector;
    logic [ChanW-1:0] bright;
    logic [ChanW-1:0] p;
    logic [QpW-1:0]   qp;
    logic [QpW-1:0]   tp;
  } recip_t;

  recip_t            recip_d, recip_q;
  logic [ScaleW-1:0] xq, xt;
  logic [ChanW-1:0]  q, t, v, p;
  logic [ChanW-1:0]  red_d, green_d, blue_d;
  logic [ChanW-1:0]  red_q, green_q, blue_q;

  // 979200 = 256 * 3825: drop eight bits, then multiply by 1/3825
  always_comb begin
    xq             = scale_i.mq + HalfDenQt;
    xt             = scale_i.mt + HalfDenQt;
    recip_d.sector = scale_i.sector;
    recip_d.bright = scale_i.bright;
    recip_d.p      = scale_i.pm[Sh255 +: ChanW];
    recip_d.qp     = QpW'(xq[ScaleW-1:8]) * QpW'(Inv3825);
    recip_d.tp     = QpW'(xt[ScaleW-1:8]) * QpW'(Inv3825);
  end

  always_ff @(posedge clk_i) begin
    if (en_i.s4) begin
      recip_q <= recip_d;
    end
  end

  always_comb begin
    q = recip_q.qp[Sh3825 +: ChanW];
    t = recip_q.tp[Sh3825 +: ChanW];
    v = recip_q.bright;
    p = recip_q.p;
    case (recip_q.sector)
      SecRed: begin
        red_d = v; green_d = t; blue_d = p;
      end
      SecYellow: begin
        red_d = q; green_d = v; blue_d = p;
      end
      SecGreen: begin
        red_d = p; green_d = v; blue_d = t;
      end
      SecCyan: begin
        red_d = p; green_d = q; blue_d = v;
      end
      SecBlue: begin
        red_d = t; green_d = p; blue_d = v;
      end
      default: begin
        red_d = v; green_d = p; blue_d = q;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en_i.s5) begin
      red_q   <= red_d;
      green_q <= green_d;
      blue_q  <= blue_d;
    end
  end

  assign red_o   = red_q;
  assign green_o = green_q;
  assign blue_o  = blue_q;

endmodule

>>> hw/rtl/hsv_to_rgb.sv
// hsv_to_rgb top level: stream ports, stage valid bits and stall control.
// Depends on hsvrgb_pkg, hsvrgb_split, hsvrgb_prod and hsvrgb_norm.
//
// Converts one HSV color per request to 8-bit RGB.
// Input channel s_axis: hue (1/64 degree, 15 bits), saturation and
// brightness (8 bits each). Output channel m_axis: red, green, blue.
// An accepted request passes through five register stages (sector split,
// saturation products, value scaling, reciprocal divide, sector
// permutation) on its way to tvalid on m_axis.
// Throughput: one request per clock when m_axis_tready stays high.
// Each stage holds a valid bit; a stage takes new data when it is empty or
// the stage after it moves, so bubbles close up under a stall.
// When the receiver stalls, the result is held on m_axis and the pipeline
// keeps accepting until all five stages are full; s_axis_tready then drops.
// Nothing is lost or repeated across a stall.
// Reset clears all valid bits; the block is ready in the first cycle after.
// A hue of 23040 or more wraps by one full turn.
`timescale 1ns / 1ps

module hsv_to_rgb import hsvrgb_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid_i,
  output logic                s_axis_tready_o,
  // [14:0] hue, [22:15] saturation, [30:23] brightness, [31] zero
  input  logic [DataInW-1:0]  s_axis_tdata_i,
  output logic                m_axis_tvalid_o,
  input  logic                m_axis_tready_i,
  // [7:0] red, [15:8] green, [23:16] blue
  output logic [DataOutW-1:0] m_axis_tdata_o
);

  stage_en_t        en;
  logic [5:1]       vld_d, vld_q;
  split_t           split;
  scale_t           scale;
  logic [ChanW-1:0] red, green, blue;

  // a stage moves when empty or when the next one moves
  always_comb begin
    en.s5 = ~vld_q[5] | m_axis_tready_i;
    en.s4 = ~vld_q[4] | en.s5;
    en.s3 = ~vld_q[3] | en.s4;
    en.s2 = ~vld_q[2] | en.s3;
    en.s1 = ~vld_q[1] | en.s2;
    vld_d[1] = en.s1 ? s_axis_tvalid_i : vld_q[1];
    vld_d[2] = en.s2 ? vld_q[1] : vld_q[2];
    vld_d[3] = en.s3 ? vld_q[2] : vld_q[3];
    vld_d[4] = en.s4 ? vld_q[3] : vld_q[4];
    vld_d[5] = en.s5 ? vld_q[4] : vld_q[5];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  hsvrgb_split u_split (
    .clk_i    (clk_i),
    .en_i     (en),
    .hue_i    (s_axis_tdata_i[HueW-1:0]),
    .sat_i    (s_axis_tdata_i[HueW +: ChanW]),
    .bright_i (s_axis_tdata_i[HueW+ChanW +: ChanW]),
    .split_o  (split)
  );

  hsvrgb_prod u_prod (
    .clk_i   (clk_i),
    .en_i    (en),
    .split_i (split),
    .scale_o (scale)
  );

  hsvrgb_norm u_norm (
    .clk_i   (clk_i),
    .en_i    (en),
    .scale_i (scale),
    .red_o   (red),
    .green_o (green),
    .blue_o  (blue)
  );

  assign s_axis_tready_o = en.s1;
  assign m_axis_tvalid_o = vld_q[5];
  assign m_axis_tdata_o  = {blue, green, red};

endmodule

>>> verif/tb_hsv_to_rgb.sv
// Self-checking testbench for hsv_to_rgb: a table of directed colors, then
// random requests under random stalls on both streams. Depends on hsvrgb_pkg.
`timescale 1ns / 1ps

module tb_hsv_to_rgb;
  import hsvrgb_pkg::*;

  localparam int unsigned HueTurn     = 23040;
  localparam int          NumDirected = 25;
  localparam int          NumRandom   = 1500;
  localparam int          MaxGap      = 18;
  localparam int          LongHold    = 200;
  localparam int          HoldAt      = 400;
  localparam int          DrainCycles = 20;

  typedef struct packed {
    logic [ChanW-1:0] red;
    logic [ChanW-1:0] green;
    logic [ChanW-1:0] blue;
  } rgb_t;

  typedef struct packed {
    logic [HueW-1:0]  hue;
    logic [ChanW-1:0] sat;
    logic [ChanW-1:0] bright;
    logic             fixed;   // rgb typed in below, else predicted
    rgb_t             rgb;
  } color_row_t;

  color_row_t color_rows [NumDirected] = '{
    '{15'd0,     8'd0,   8'd0,   1'b1, '{8'd0,   8'd0,   8'd0}},
    '{15'd0,     8'd255, 8'd255, 1'b1, '{8'd255, 8'd0,   8'd0}},
    '{15'd3840,  8'd255, 8'd255, 1'b1, '{8'd255, 8'd255, 8'd0}},
    '{15'd7680,  8'd255, 8'd255, 1'b1, '{8'd0,   8'd255, 8'd0}},
    '{15'd11520, 8'd255, 8'd255, 1'b1, '{8'd0,   8'd255, 8'd255}},
    '{15'd15360, 8'd255, 8'd255, 1'b1, '{8'd0,   8'd0,   8'd255}},
    '{15'd19200, 8'd255, 8'd255, 1'b1, '{8'd255, 8'd0,   8'd255}},
    '{15'd23039, 8'd0,   8'd255, 1'b1, '{8'd255, 8'd255, 8'd255}},
    '{15'd32767, 8'd0,   8'd128, 1'b1, '{8'd128, 8'd128, 8'd128}},
    '{15'd23040, 8'd255, 8'd255, 1'b1, '{8'd255, 8'd0,   8'd0}},
    '{15'd0,     8'd255, 8'd0,   1'b1, '{8'd0,   8'd0,   8'd0}},
    '{15'd1920,  8'd255, 8'd255, 1'b0, '0},
    '{15'd5760,  8'd200, 8'd100, 1'b0, '0},
    '{15'd9600,  8'd128, 8'd255, 1'b0, '0},
    '{15'd13440, 8'd255, 8'd77,  1'b0, '0},
    '{15'd17280, 8'd1,   8'd254, 1'b0, '0},
    '{15'd21120, 8'd254, 8'd1,   1'b0, '0},
    '{15'd3839,  8'd255, 8'd255, 1'b0, '0},
    '{15'd3841,  8'd255, 8'd255, 1'b0, '0},
    '{15'd23039, 8'd255, 8'd255, 1'b0, '0},
    '{15'd32767, 8'd255, 8'd255, 1'b0, '0},
    '{15'd16383, 8'd170, 8'd85,  1'b0, '0},
    '{15'd21845, 8'd85,  8'd170, 1'b0, '0},
    '{15'd10922, 8'd255, 8'd128, 1'b0, '0},
    '{15'd30000, 8'd17,  8'd240, 1'b0, '0}
  };

  logic                clk_i;
  logic                rst_ni         = 1'b0;
  logic                s_tvalid       = 1'b0;
  logic [DataInW-1:0]  s_tdata        = '0;
  logic                m_tready       = 1'b0;
  logic                s_axis_tready_o;
  logic                m_axis_tvalid_o;
  logic [DataOutW-1:0] m_axis_tdata_o;

  // expectation riding along with the request on the input stream
  logic                req_fixed      = 1'b0;
  rgb_t                req_rgb        = '0;

  rgb_t                pending_rgb [$];
  int                  n_errors       = 0;
  int                  n_colors_out   = 0;

  hsv_to_rgb u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_tdata),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    #2_000_000;
    $display("status: fail");
    $finish;
  end

  // floor(num / den + 1/2)
  function automatic longint unsigned round_div(longint unsigned num, longint unsigned den);
    return (2 * num + den) / (2 * den);
  endfunction

  function automatic rgb_t convert_hsv(logic [HueW-1:0] hue_in, logic [ChanW-1:0] sat,
                                       logic [ChanW-1:0] bright);
    longint unsigned hue;
    longint unsigned frac;
    longint unsigned s;
    longint unsigned v;
    longint unsigned dim;
    longint unsigned fall;
    longint unsigned rise;
    sector_t         sector;
    rgb_t            rgb;
    hue = hue_in;
    s = sat;
    v = bright;
    if (hue >= HueTurn) hue = hue - HueTurn;
    sector = sector_t'(hue / HueSector);
    frac = hue % HueSector;
    dim  = round_div(v * (Full8 - s), Full8);
    fall = round_div(v * (DenQt - frac * s), DenQt);
    rise = round_div(v * (DenQt - (HueSector - frac) * s), DenQt);
    case (sector)
      SecRed:    rgb = '{bright, rise[7:0], dim[7:0]};
      SecYellow: rgb = '{fall[7:0], bright, dim[7:0]};
      SecGreen:  rgb = '{dim[7:0], bright, rise[7:0]};
      SecCyan:   rgb = '{dim[7:0], fall[7:0], bright};
      SecBlue:   rgb = '{rise[7:0], dim[7:0], bright};
      default:   rgb = '{bright, dim[7:0], fall[7:0]};   // magenta sector
    endcase
    return rgb;
  endfunction

  task automatic report_channel(string name, logic [ChanW-1:0] want, logic [ChanW-1:0] got);
    if (want !== got) begin
      n_errors++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endtask

  task automatic send_color(logic [HueW-1:0] hue, logic [ChanW-1:0] sat,
                            logic [ChanW-1:0] bright, logic fixed, rgb_t rgb, int gap);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_tvalid  <= 1'b1;
    s_tdata   <= {1'b0, bright, sat, hue};
    req_fixed <= fixed;
    req_rgb   <= rgb;
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
  endtask

  // input side: one expectation per accepted request
  always @(posedge clk_i) begin
    if (rst_ni && s_tvalid && s_axis_tready_o) begin
      if (req_fixed) pending_rgb.push_back(req_rgb);
      else pending_rgb.push_back(convert_hsv(s_tdata[14:0], s_tdata[22:15], s_tdata[30:23]));
    end
  end

  // output side: compare against the oldest expectation
  always @(posedge clk_i) begin : check_color
    rgb_t want;
    rgb_t got;
    if (rst_ni && m_axis_tvalid_o && m_tready) begin
      got = '{m_axis_tdata_o[7:0], m_axis_tdata_o[15:8], m_axis_tdata_o[23:16]};
      if (pending_rgb.size() == 0) begin
        n_errors++;
        $display("%0t: unexpected color, expected none, actual %h", $time, m_axis_tdata_o);
      end else begin
        want = pending_rgb.pop_front();
        report_channel("red", want.red, got.red);
        report_channel("green", want.green, got.green);
        report_channel("blue", want.blue, got.blue);
      end
    end
  end

  // receiver: random stalls, stall-free stretches and one long hold-off
  initial begin : drain_colors
    int stall;
    @(posedge rst_ni);
    forever begin
      if (n_colors_out == HoldAt) stall = LongHold;
      else if ((n_colors_out / 90) % 3 == 2) stall = 0;
      else stall = $urandom_range(0, MaxGap);
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_tready <= 1'b1;
      @(posedge clk_i);
      while (!m_axis_tvalid_o) @(posedge clk_i);
      n_colors_out++;
    end
  end

  initial begin : feed_colors
    logic [HueW-1:0]  hue;
    logic [ChanW-1:0] sat;
    logic [ChanW-1:0] bright;
    int               gap;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < NumDirected; i++) begin
      gap = (i < 12) ? 0 : $urandom_range(0, MaxGap);
      send_color(color_rows[i].hue, color_rows[i].sat, color_rows[i].bright,
                 color_rows[i].fixed, color_rows[i].rgb, gap);
    end

    for (int n = 0; n < NumRandom; n++) begin
      case ($urandom_range(0, 9))
        0:       hue = HueW'($urandom_range(HueTurn, 32767));           // wraps
        1:       hue = HueW'($urandom);
        2:       hue = HueW'($urandom_range(0, 5) * HueSector
                             + (($urandom_range(0, 1) == 1) ? 0 : HueSector - 1));
        default: hue = HueW'($urandom_range(0, HueTurn - 1));
      endcase
      sat    = ($urandom_range(0, 4) == 0) ? ChanW'($urandom_range(0, 1) * 255) : ChanW'($urandom);
      bright = ($urandom_range(0, 4) == 0) ? ChanW'($urandom_range(0, 1) * 255) : ChanW'($urandom);
      gap = ((n / 120) % 3 == 1) ? 0 : $urandom_range(0, MaxGap);
      send_color(hue, sat, bright, 1'b0, '0, gap);
    end
    s_tvalid <= 1'b0;
    // let the last accepted request land in the queue before watching it drain
    @(posedge clk_i);

    while (pending_rgb.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (n_errors == 0 && pending_rgb.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

>>> files.f
hw/rtl/hsvrgb_pkg.sv
hw/rtl/hsvrgb_split.sv
hw/rtl/hsvrgb_prod.sv
hw/rtl/hsvrgb_norm.sv
hw/rtl/hsv_to_rgb.sv
verif/tb_hsv_to_rgb.sv
